FILE: rtl/core/srgb_pixel_converter_assert.svh
// Assertion macros for the sRGB pixel converter.
// Used by the top level only; no other dependencies.
`ifndef SRGB_PIXEL_CONVERTER_ASSERT_SVH
`define SRGB_PIXEL_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/spc_pkg.sv
// Package for the sRGB pixel converter: payload and stage types, pipeline
// constants and the decode and encode-threshold tables built at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int CHANNELS     = 3;
    localparam int SEARCH_BITS  = 8;
    localparam int PIPE_STAGES  = SEARCH_BITS + 1;
    localparam int LUT_DEPTH    = 256;
    localparam int DEC_LIN_LAST = 10;
    localparam int ENC_LIN_LAST = 10;

    localparam real CURVE_GAMMA = 2.4;
    localparam real CURVE_DEN   = 10761.0;
    localparam real CODE_SCALE  = 65535.0;
    localparam real HALF        = 0.5;

    localparam logic [16:0] ALPHA_BIAS  = 17'd128;
    localparam logic [16:0] ALPHA_RECIP = 17'd65281;
    localparam int          ALPHA_SHIFT = 24;

    typedef logic [LUT_DEPTH-1:0][15:0] t_lut;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
    } t_pixel_out;

    typedef struct packed {
        logic                           dir;
        logic [CHANNELS-1:0][15:0]      val;
        logic [CHANNELS-1:0][SEARCH_BITS-1:0] k;
        logic [15:0]                    alpha;
    } t_stage;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] adv;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe_ctl;

    // byte -> linear code, round(curve(byte/255) * 65535)
    function automatic t_lut f_build_dec();
        t_lut lut;
        int   b;
        int   n;
        real  u;
        real  v;
        for (b = 0; b < LUT_DEPTH; b++) begin
            if (b <= DEC_LIN_LAST) begin
                n = (13107000 * b + 329460) / 658920;
            end else begin
                u = real'(40 * b + 561) / CURVE_DEN;
                v = $pow(u, CURVE_GAMMA) * CODE_SCALE + HALF;
                n = $rtoi(v);
            end
            lut[b] = 16'(n);
        end
        return lut;
    endfunction

    // smallest linear code that encodes to byte k or above
    function automatic t_lut f_build_enc();
        t_lut thr;
        int   k;
        int   n;
        real  x;
        thr[0] = 16'd0;
        for (k = 1; k < LUT_DEPTH; k++) begin
            if (k <= ENC_LIN_LAST) begin
                n = (13107000 * k - 6553500 + 658919) / 658920;
            end else begin
                x = $pow(real'(40 * k + 541) / CURVE_DEN, CURVE_GAMMA) * CODE_SCALE;
                n = $rtoi(x);
                if (real'(n) < x) begin
                    n = n + 1;
                end
            end
            thr[k] = 16'(n);
        end
        return thr;
    endfunction

    localparam t_lut DEC_LUT = f_build_dec();
    localparam t_lut ENC_THR = f_build_enc();

endpackage

FILE: rtl/core/spc_stream_if.sv
// Valid/ready stream channel carrying one pixel payload per beat.
// Payload type is supplied by the instantiating level.
`timescale 1ns / 1ps

interface spc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/srgb_pixel_converter.sv
// sRGB <-> 16-bit linear RGBA pixel converter, one pixel per beat.
// Pipeline: lookup stage + 8 search stages.
// Throughput: one pixel per clock while the output accepts; stages fill past a stalled output beat.
// Reset clears all stage valid bits and sets direction to decode.
// Depends on spc_pkg, spc_stream_if, spc_pipe_ctrl, spc_front, spc_search.
`timescale 1ns / 1ps

`include "srgb_pixel_converter_assert.svh"

module srgb_pixel_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    spc_stream_if.sink    i_pix,
    spc_stream_if.source  o_pix
);
    import spc_pkg::*;

    logic      r_direction;
    t_pipe_ctl ctl;
    t_stage    front_stage;
    t_stage    res_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_wdata;
        end
    end

    spc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_ctl       (ctl)
    );

    spc_front u_front (
        .i_clk   (i_clk),
        .i_en    (ctl.adv[0]),
        .i_dir   (r_direction),
        .i_pix   (i_pix.data),
        .o_stage (front_stage)
    );

    spc_search u_search (
        .i_clk   (i_clk),
        .i_adv   (ctl.adv[PIPE_STAGES-1:1]),
        .i_stage (front_stage),
        .o_stage (res_stage)
    );

    assign i_pix.ready = ctl.adv[0];
    assign o_pix.valid = ctl.vld[PIPE_STAGES-1];

    always_comb begin
        if (res_stage.dir) begin
            o_pix.data.red_out   = {8'h00, res_stage.k[0]};
            o_pix.data.green_out = {8'h00, res_stage.k[1]};
            o_pix.data.blue_out  = {8'h00, res_stage.k[2]};
        end else begin
            o_pix.data.red_out   = res_stage.val[0];
            o_pix.data.green_out = res_stage.val[1];
            o_pix.data.blue_out  = res_stage.val[2];
        end
        o_pix.data.alpha_out = res_stage.alpha;
    end

    `SPC_ASSERT_IMPLY(a_enc_byte_range, i_clk, i_rst_n, o_pix.valid && res_stage.dir, o_pix.data.red_out[15:8] == 8'h00 && o_pix.data.green_out[15:8] == 8'h00 && o_pix.data.blue_out[15:8] == 8'h00 && o_pix.data.alpha_out[15:8] == 8'h00, "encode beat exceeds byte range")
    `SPC_ASSERT_IMPLY(a_dec_alpha_repl, i_clk, i_rst_n, o_pix.valid && !res_stage.dir, o_pix.data.alpha_out[15:8] == o_pix.data.alpha_out[7:0], "decode alpha not byte times 257")
    `SPC_ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n, !o_pix.valid, i_pix.ready, "input stalled with empty output stage")
    `SPC_ASSERT_NEXT(a_dir_write, i_clk, i_rst_n, i_cfg_we, r_direction == $past(i_cfg_wdata), "direction register missed write")

endmodule

FILE: rtl/core/spc_pipe_ctrl.sv
// Valid bits and per-stage advance enables for the converter pipeline.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output spc_pkg::t_pipe_ctl o_ctl
);
    import spc_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] adv;

    always_comb begin
        adv[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_out_ready;
        for (int s = PIPE_STAGES - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    always_comb begin
        n_vld[0] = adv[0] ? i_in_valid : r_vld[0];
        for (int s = 1; s < PIPE_STAGES; s++) begin
            n_vld[s] = adv[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.adv = adv;
    assign o_ctl.vld = r_vld;

endmodule

FILE: rtl/core/spc_front.sv
// First pipeline stage: decode table lookup and alpha rescale.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_front (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_dir,
    input  spc_pkg::t_pixel_in i_pix,
    output spc_pkg::t_stage    o_stage
);
    import spc_pkg::*;

    t_stage                    r_stage;
    t_stage                    n_stage;
    logic [CHANNELS-1:0][15:0] chan;
    logic [16:0]               alpha_biased;
    logic [33:0]               alpha_prod;

    assign chan[0] = i_pix.red_in;
    assign chan[1] = i_pix.green_in;
    assign chan[2] = i_pix.blue_in;

    // round(code / 257) as a reciprocal multiply
    assign alpha_biased = {1'b0, i_pix.alpha_in} + ALPHA_BIAS;
    assign alpha_prod   = 34'(alpha_biased) * 34'(ALPHA_RECIP);

    always_comb begin
        n_stage.dir = i_dir;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_stage.val[ch] = i_dir ? chan[ch] : DEC_LUT[chan[ch][7:0]];
            n_stage.k[ch]   = '0;
        end
        if (i_dir) begin
            n_stage.alpha = {8'h00, alpha_prod[ALPHA_SHIFT+7:ALPHA_SHIFT]};
        end else begin
            n_stage.alpha = {i_pix.alpha_in[7:0], i_pix.alpha_in[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/core/spc_search.sv
// Encode search pipeline: one threshold compare per bit per stage, MSB first.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_search (
    input  logic                               i_clk,
    input  logic [spc_pkg::SEARCH_BITS-1:0]    i_adv,
    input  spc_pkg::t_stage                    i_stage,
    output spc_pkg::t_stage                    o_stage
);
    import spc_pkg::*;

    t_stage r_stg   [SEARCH_BITS];
    t_stage n_stg   [SEARCH_BITS];
    t_stage stg_in  [SEARCH_BITS];

    for (genvar s = 0; s < SEARCH_BITS; s++) begin : g_stage
        logic [CHANNELS-1:0][SEARCH_BITS-1:0] cand;

        if (s == 0) begin : g_first
            assign stg_in[s] = i_stage;
        end else begin : g_rest
            assign stg_in[s] = r_stg[s-1];
        end

        always_comb begin
            n_stg[s] = stg_in[s];
            for (int ch = 0; ch < CHANNELS; ch++) begin
                cand[ch] = stg_in[s].k[ch] | (SEARCH_BITS'(1) << (SEARCH_BITS - 1 - s));
                if (stg_in[s].val[ch] >= ENC_THR[cand[ch]]) begin
                    n_stg[s].k[ch] = cand[ch];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[s]) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    assign o_stage = r_stg[SEARCH_BITS-1];

endmodule
